// ===== design/ffha_pkg.sv =====
// Shared constants, types and commands of the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned ARENA_BYTES  = 262144;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned SPLIT_MARGIN = 4;
  localparam logic [31:0] BASE_RESET   = 32'hC040_0000;

  localparam int unsigned OFS_W   = $clog2(ARENA_BYTES);
  localparam int unsigned COUNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIZE_W  = 20;

  localparam logic [OFS_W-1:0] HDR_OFS  = OFS_W'(HEADER_BYTES);
  localparam logic [OFS_W-1:0] HEAD_LEN = OFS_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [SIZE_W:0]  SPLIT_EXTRA = (SIZE_W+1)'(HEADER_BYTES + SPLIT_MARGIN);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic             is_free;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] len;
  } cell_fields_t;

  // Flags of the cell holding the scan token, all zero elsewhere.
  typedef struct packed {
    logic             valid;
    logic             fit;
    logic             split_ok;
    logic             own;
    logic             pair;
    logic [OFS_W-1:0] start;
  } cell_flags_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_START,
    CMD_ADV,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_RELEASE,
    CMD_MERGE
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_MSTART,
    S_MERGE,
    S_RESP
  } state_t;

endpackage

// ===== design/ffha_cell.sv =====
// One table entry of the allocator, with its share of the scan token.
module ffha_cell import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head,
  input  cell_fields_t      reset_fields,
  input  cell_cmd_t         cmd,
  input  logic [SIZE_W-1:0] size,
  input  logic [31:0]       target,
  input  cell_fields_t      left_fields,
  input  logic              left_tok,
  input  cell_fields_t      right_fields,
  output cell_fields_t      fields,
  output logic              tok,
  output cell_flags_t       flags
);

  cell_fields_t     fields_r, fields_nxt;
  logic             tok_r, tok_nxt;
  logic             behind_r, behind_nxt;
  logic [OFS_W-1:0] size_ofs;

  assign size_ofs = size[OFS_W-1:0];

  always_comb begin
    fields_nxt = fields_r;
    tok_nxt    = tok_r;
    behind_nxt = behind_r;
    unique case (cmd)
      CMD_START: begin
        tok_nxt    = head;
        behind_nxt = !head;
      end
      CMD_ADV: begin
        tok_nxt    = left_tok;
        behind_nxt = behind_r & !left_tok;
      end
      CMD_SPLIT: begin
        if (tok_r) begin
          fields_nxt.len     = size_ofs;
          fields_nxt.is_free = 1'b0;
        end else if (left_tok) begin
          fields_nxt.valid   = 1'b1;
          fields_nxt.is_free = 1'b1;
          fields_nxt.start   = left_fields.start + HDR_OFS + size_ofs;
          fields_nxt.len     = left_fields.len - size_ofs - HDR_OFS;
        end else if (behind_r) begin
          fields_nxt = left_fields;
        end
      end
      CMD_TAKE:    if (tok_r) fields_nxt.is_free = 1'b0;
      CMD_RELEASE: if (tok_r) fields_nxt.is_free = 1'b1;
      CMD_MERGE: begin
        if (tok_r) begin
          fields_nxt.len = fields_r.len + HDR_OFS + right_fields.len;
        end else if (behind_r) begin
          fields_nxt = right_fields;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= reset_fields;
      tok_r    <= 1'b0;
      behind_r <= 1'b0;
    end else begin
      fields_r <= fields_nxt;
      tok_r    <= tok_nxt;
      behind_r <= behind_nxt;
    end
  end

  assign fields = fields_r;
  assign tok    = tok_r;

  always_comb begin
    flags.valid    = tok_r & fields_r.valid;
    flags.fit      = tok_r & fields_r.valid & fields_r.is_free
                     & ({{(SIZE_W-OFS_W){1'b0}}, fields_r.len} >= size);
    flags.split_ok = tok_r & ({{(SIZE_W+1-OFS_W){1'b0}}, fields_r.len}
                     > ({1'b0, size} + SPLIT_EXTRA));
    flags.own      = tok_r & fields_r.valid & !fields_r.is_free
                     & (target[31:OFS_W] == '0) & (fields_r.start == target[OFS_W-1:0]);
    flags.pair     = tok_r & fields_r.valid & fields_r.is_free
                     & right_fields.valid & right_fields.is_free;
    flags.start    = tok_r ? fields_r.start : '0;
  end

endmodule

// ===== design/ffha_chain.sv =====
// The row of table cells, wired to their neighbours, with the token flags gathered.
module ffha_chain import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_cmd_t         cmd,
  input  logic [SIZE_W-1:0] size,
  input  logic [31:0]       target,
  output cell_flags_t       flags
);

  cell_fields_t cf   [MAX_BLOCKS];
  logic         tk   [MAX_BLOCKS];
  cell_flags_t  fl   [MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    cell_fields_t rst_f, lf, rf;
    logic         lt;
    if (k == 0) begin : g_head
      assign rst_f = '{valid: 1'b1, is_free: 1'b1, start: '0, len: HEAD_LEN};
      assign lf    = '0;
      assign lt    = 1'b0;
    end else begin : g_body
      assign rst_f = '0;
      assign lf    = cf[k-1];
      assign lt    = tk[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign rf = '0;
    end else begin : g_mid
      assign rf = cf[k+1];
    end
    ffha_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .head        (k == 0),
      .reset_fields(rst_f),
      .cmd         (cmd),
      .size        (size),
      .target      (target),
      .left_fields (lf),
      .left_tok    (lt),
      .right_fields(rf),
      .fields      (cf[k]),
      .tok         (tk[k]),
      .flags       (fl[k])
    );
  end

  always_comb begin
    flags = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      flags = flags | fl[k];
    end
  end

endmodule

// ===== design/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: sequencer, count and result register.
//
//   Channel | Direction | Ports
//   --------+-----------+----------------------------------------------------
//   in      | input     | in_valid, in_ready, in_op, in_request_size,
//           |           | in_free_address
//   out     | output    | out_valid, out_ready, out_result_address, out_status
//   cfg     | input     | cfg_wr_en, cfg_wr_data (heap_base)
//
// One request is handled at a time. A scan token walks the cell row one entry
// per cycle, but stays put after a merge, which removes an entry from the walk.
// Synchronous reset restores one free block spanning the arena; no clearing
// pass is needed. A finished result waits in the response state until the
// output register is free, and input beats are taken only when idle.
module first_fit_heap_allocator_core import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [SIZE_W-1:0] in_request_size,
  input  logic [31:0]       in_free_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_result_address,
  output logic [1:0]        out_status,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [31:0]        base_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [31:0]        target_r, target_nxt;
  logic [31:0]        res_r, res_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;
  cell_cmd_t          cmd;
  cell_flags_t        flags;
  logic               in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;

  ffha_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .size  (size_r),
    .target(target_r),
    .flags (flags)
  );

  // Sequencer. Each state issues one command to the whole row per cycle.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    target_nxt    = target_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r & !out_ready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    cmd           = CMD_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          size_nxt   = in_request_size;
          target_nxt = in_free_address - base_r - 32'(HEADER_BYTES);
          res_nxt    = '0;
          if (in_op == OP_ALLOC) begin
            cmd       = CMD_START;
            state_nxt = S_ALLOC;
          end else if (in_free_address == '0) begin
            stat_nxt  = ST_NULL;
            state_nxt = S_RESP;
          end else begin
            cmd       = CMD_START;
            state_nxt = S_FREE;
          end
        end
      end
      S_ALLOC: begin
        if (!flags.valid) begin
          stat_nxt  = ST_OOM;
          state_nxt = S_RESP;
        end else if (flags.fit) begin
          // The first block large enough; split it when worthwhile and the row has room.
          if (flags.split_ok && (count_r < COUNT_W'(MAX_BLOCKS))) begin
            cmd       = CMD_SPLIT;
            count_nxt = count_r + 1'b1;
          end else begin
            cmd = CMD_TAKE;
          end
          res_nxt   = base_r + 32'(flags.start) + 32'(HEADER_BYTES);
          stat_nxt  = ST_OK;
          state_nxt = S_RESP;
        end else begin
          cmd = CMD_ADV;
        end
      end
      S_FREE: begin
        if (!flags.valid) begin
          stat_nxt  = ST_BAD;
          state_nxt = S_RESP;
        end else if (flags.own) begin
          cmd       = CMD_RELEASE;
          stat_nxt  = ST_OK;
          state_nxt = S_MSTART;
        end else begin
          cmd = CMD_ADV;
        end
      end
      S_MSTART: begin
        cmd       = CMD_START;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        // The token stays put after a merge so that longer free runs fold up fully.
        if (!flags.valid) begin
          state_nxt = S_RESP;
        end else if (flags.pair) begin
          cmd       = CMD_MERGE;
          count_nxt = count_r - 1'b1;
        end else begin
          cmd = CMD_ADV;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= COUNT_W'(1);
      base_r      <= BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    target_r   <= target_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_stat_r;

endmodule
